>>> src/socf_pkg.sv
`default_nettype none

package socf_pkg;

   localparam int unsigned STEP_W = 5;
   localparam logic [STEP_W-1:0] STEP_IDLE = 5'd0;
   localparam logic [STEP_W-1:0] STEP_OUT  = 5'd17;

   localparam int unsigned OPD_W  = 34;
   localparam int unsigned PROD_W = 2 * OPD_W;
   localparam int unsigned MAG_W  = 28;

   // dt = us * 4294 + floor(us * 15114 / 15625), the division done by reciprocal.
   localparam logic [OPD_W-1:0] DT_INT_MUL     = 34'd4294;
   localparam logic [OPD_W-1:0] DT_FRAC_MUL    = 34'd15114;
   localparam logic [OPD_W-1:0] DT_RECIP       = 34'd1125899907;
   localparam int unsigned      DT_RECIP_SHIFT = 44;

   localparam logic [7:0] GAIN_RESET   = 8'd10;
   localparam logic       CSR_GAIN_IDX = 1'b0;

   typedef enum logic [2:0] {
      OPA_US,
      OPA_PROD,
      OPA_GAIN,
      OPA_DT,
      OPA_T
   } opa_sel_type;

   typedef enum logic [3:0] {
      OPB_INT,
      OPB_FRAC,
      OPB_RECIP,
      OPB_GAIN,
      OPB_ERR,
      OPB_DT,
      OPB_SH,
      OPB_SL,
      OPB_DIVM
   } opb_sel_type;

   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_LOAD,
      ACT_ERR,
      ACT_T_PROD,
      ACT_DT,
      ACT_INTEG,
      ACT_SUM_S,
      ACT_T_ADD,
      ACT_EST,
      ACT_DIFF,
      ACT_ACCUM,
      ACT_ABS,
      ACT_OUT
   } act_type;

   typedef enum logic [1:0] {
      BR_NEXT,
      BR_WAIT_REQ,
      BR_WAIT_RSP,
      BR_JUMP
   } br_type;

   typedef struct packed {
      opa_sel_type       a_sel;
      opb_sel_type       b_sel;
      act_type           act;
      br_type            br;
      logic [STEP_W-1:0] target;
   } uc_word_type;

   // The multiplier product is registered, so each step consumes the product
   // of the operands selected one step earlier.
   function automatic uc_word_type uc_fetch(input logic [STEP_W-1:0] step);
      uc_word_type w;
      case (step)
         5'd0: w = '{OPA_US, OPB_INT, ACT_LOAD, BR_WAIT_REQ, STEP_IDLE};
         5'd1: w = '{OPA_US, OPB_INT, ACT_ERR, BR_NEXT, STEP_IDLE};
         5'd2: w = '{OPA_US, OPB_FRAC, ACT_T_PROD, BR_NEXT, STEP_IDLE};
         5'd3: w = '{OPA_PROD, OPB_RECIP, ACT_NONE, BR_NEXT, STEP_IDLE};
         5'd4: w = '{OPA_GAIN, OPB_GAIN, ACT_DT, BR_NEXT, STEP_IDLE};
         5'd5: w = '{OPA_PROD, OPB_ERR, ACT_NONE, BR_NEXT, STEP_IDLE};
         5'd6: w = '{OPA_PROD, OPB_DT, ACT_NONE, BR_NEXT, STEP_IDLE};
         5'd7: w = '{OPA_GAIN, OPB_ERR, ACT_INTEG, BR_NEXT, STEP_IDLE};
         5'd8: w = '{OPA_GAIN, OPB_GAIN, ACT_SUM_S, BR_NEXT, STEP_IDLE};
         5'd9: w = '{OPA_DT, OPB_SH, ACT_NONE, BR_NEXT, STEP_IDLE};
         5'd10: w = '{OPA_DT, OPB_SL, ACT_T_PROD, BR_NEXT, STEP_IDLE};
         5'd11: w = '{OPA_DT, OPB_SL, ACT_T_ADD, BR_NEXT, STEP_IDLE};
         5'd12: w = '{OPA_DT, OPB_SL, ACT_EST, BR_NEXT, STEP_IDLE};
         5'd13: w = '{OPA_DT, OPB_SL, ACT_DIFF, BR_NEXT, STEP_IDLE};
         5'd14: w = '{OPA_DT, OPB_SL, ACT_ACCUM, BR_NEXT, STEP_IDLE};
         5'd15: w = '{OPA_T, OPB_DIVM, ACT_ABS, BR_NEXT, STEP_IDLE};
         5'd16: w = '{OPA_T, OPB_DIVM, ACT_NONE, BR_NEXT, STEP_IDLE};
         5'd17: w = '{OPA_T, OPB_DIVM, ACT_OUT, BR_WAIT_RSP, STEP_IDLE};
         default: w = '{OPA_US, OPB_INT, ACT_NONE, BR_JUMP, STEP_IDLE};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

>>> src/second_order_complementary_filter.sv
// Second-order complementary filter for one axis with a moving average over the
// last SMOOTH_LEN estimates. Each input beat on req_ carries an accelerometer
// angle, a gyro rate and the loop interval in microseconds; each one yields
// exactly one output beat on rsp_ with the smoothed angle, saturated to 16 bits,
// which also becomes the reference angle for the next beat. The gain K is set
// through the csr_ port (register 0, reset value 10) and should only be written
// while the filter is idle. All work runs as an 18-step microprogram on a single
// shared 34 x 34 multiplier with a registered product. The result is registered in
// the last step, and a new input beat is taken only once the program has returned
// to its first step. If the previous result has not been taken yet, the program
// waits in its last step until the output register is free, but the next input
// beat is still accepted while a finished result waits.
`default_nettype none

module second_order_complementary_filter #(
   parameter int unsigned SMOOTH_LEN = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output      logic        req_tready,
   // [15:0] acc_angle, [31:16] gyro_rate, [47:32] interval_us
   input  wire logic [47:0] req_tdata,

   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // [15:0] filtered_angle
   output      logic [15:0] rsp_tdata,

   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output      logic [31:0] csr_prdata,
   output      logic        csr_pready
);

   localparam int unsigned SLOT_W    = (SMOOTH_LEN > 1) ? $clog2(SMOOTH_LEN) : 1;
   localparam int unsigned DIV_SHIFT = socf_pkg::MAG_W + $clog2(SMOOTH_LEN);
   localparam logic [63:0] DIV_MAGIC =
      ((64'd1 << DIV_SHIFT) + 64'(SMOOTH_LEN) - 64'd1) / 64'(SMOOTH_LEN);
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SMOOTH_LEN - 1);

   socf_pkg::uc_word_type uc;

   logic [socf_pkg::STEP_W-1:0] step_ff, step_in;
   logic                        go;
   logic                        req_fire;

   logic [7:0]  gain_ff;
   logic        rsp_valid_ff;
   logic [15:0] rsp_data_ff;
   logic [15:0] last_ff;
   logic [47:0] integ_ff;
   logic [39:0] hist_ff [SMOOTH_LEN];
   logic [43:0] sum_ff;
   logic [SLOT_W-1:0] slot_ff;

   logic [15:0] us_ff;
   logic [15:0] acc_ff;
   logic [15:0] gyro_ff;
   logic [16:0] err_ff;
   logic [28:0] dt_ff;
   logic [63:0] t_ff;
   logic [48:0] s_ff;
   logic [39:0] est_ff;
   logic        neg_ff;

   logic signed [socf_pkg::OPD_W-1:0]  mul_a, mul_b;
   logic signed [socf_pkg::PROD_W-1:0] prod_ff, prod_in;

   logic [49:0] integ_sum;
   logic [47:0] integ_sat;
   logic [26:0] ke_term;
   logic [48:0] s_calc;
   logic [48:0] est_raw;
   logic [39:0] est_sat;
   logic [39:0] hist_rd;
   logic [63:0] diff;
   logic [43:0] sum_mag;
   logic [socf_pkg::MAG_W-1:0] q_mag, q_neg;
   logic [15:0] q_res;
   logic        csr_wr;

   assign uc = socf_pkg::uc_fetch(step_ff);

   assign req_tready = (uc.br == socf_pkg::BR_WAIT_REQ);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == socf_pkg::CSR_GAIN_IDX) ? {24'd0, gain_ff} : 32'd0;

   always_comb begin
      case (uc.br)
         socf_pkg::BR_WAIT_REQ: go = req_fire;
         socf_pkg::BR_WAIT_RSP: go = !rsp_valid_ff;
         default:               go = 1'b1;
      endcase
      if (!go) begin
         step_in = step_ff;
      end else begin
         case (uc.br)
            socf_pkg::BR_NEXT,
            socf_pkg::BR_WAIT_REQ: step_in = step_ff + 1'b1;
            default:               step_in = uc.target;
         endcase
      end
   end

   always_comb begin
      case (uc.a_sel)
         socf_pkg::OPA_US:   mul_a = {18'd0, us_ff};
         socf_pkg::OPA_PROD: mul_a = prod_ff[socf_pkg::OPD_W-1:0];
         socf_pkg::OPA_GAIN: mul_a = {26'd0, gain_ff};
         socf_pkg::OPA_DT:   mul_a = {5'd0, dt_ff};
         socf_pkg::OPA_T:    mul_a = t_ff[socf_pkg::OPD_W-1:0];
         default:            mul_a = '0;
      endcase
      case (uc.b_sel)
         socf_pkg::OPB_INT:   mul_b = socf_pkg::DT_INT_MUL;
         socf_pkg::OPB_FRAC:  mul_b = socf_pkg::DT_FRAC_MUL;
         socf_pkg::OPB_RECIP: mul_b = socf_pkg::DT_RECIP;
         socf_pkg::OPB_GAIN:  mul_b = {26'd0, gain_ff};
         socf_pkg::OPB_ERR:   mul_b = {{17{err_ff[16]}}, err_ff};
         socf_pkg::OPB_DT:    mul_b = {5'd0, dt_ff};
         socf_pkg::OPB_SH:    mul_b = {s_ff[48], s_ff[48:16]};
         socf_pkg::OPB_SL:    mul_b = {18'd0, s_ff[15:0]};
         socf_pkg::OPB_DIVM:  mul_b = DIV_MAGIC[socf_pkg::OPD_W-1:0];
         default:             mul_b = '0;
      endcase
   end

   assign prod_in = mul_a * mul_b;

   always_comb begin
      integ_sum = {{2{integ_ff[47]}}, integ_ff} + {{4{prod_ff[61]}}, prod_ff[61:16]};
      if (integ_sum[49:47] != {3{integ_sum[49]}}) begin
         integ_sat = integ_sum[49] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
      end else begin
         integ_sat = integ_sum[47:0];
      end

      ke_term = {prod_ff[25:0], 1'b0} + {{11{gyro_ff[15]}}, gyro_ff};
      s_calc  = {integ_ff[47], integ_ff} + {{6{ke_term[26]}}, ke_term, 16'd0};

      est_raw = {t_ff[63], t_ff[63:16]} + {{17{last_ff[15]}}, last_ff, 16'd0};
      if (est_raw[48:39] != {10{est_raw[48]}}) begin
         est_sat = est_raw[48] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
      end else begin
         est_sat = est_raw[39:0];
      end

      hist_rd = hist_ff[slot_ff];
      diff    = {{24{est_ff[39]}}, est_ff} - {{24{hist_rd[39]}}, hist_rd};
      sum_mag = sum_ff[43] ? (44'd0 - sum_ff) : sum_ff;

      q_mag = prod_ff[DIV_SHIFT +: socf_pkg::MAG_W];
      q_neg = '0 - q_mag;
      if (neg_ff) begin
         q_res = (q_mag > 28'd32768) ? 16'h8000 : q_neg[15:0];
      end else begin
         q_res = (q_mag > 28'd32767) ? 16'h7FFF : q_mag[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= socf_pkg::STEP_IDLE;
         gain_ff      <= socf_pkg::GAIN_RESET;
         rsp_valid_ff <= 1'b0;
         last_ff      <= '0;
         integ_ff     <= '0;
         sum_ff       <= '0;
         slot_ff      <= '0;
         for (int i = 0; i < SMOOTH_LEN; i++) begin
            hist_ff[i] <= '0;
         end
      end else begin
         step_ff <= step_in;
         if (csr_wr && (csr_paddr[2] == socf_pkg::CSR_GAIN_IDX)) begin
            gain_ff <= csr_pwdata[7:0];
         end
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (uc.act)
            socf_pkg::ACT_INTEG: integ_ff <= integ_sat;
            socf_pkg::ACT_DIFF:  hist_ff[slot_ff] <= est_ff;
            socf_pkg::ACT_ACCUM: begin
               sum_ff  <= sum_ff + t_ff[43:0];
               slot_ff <= (slot_ff == SLOT_LAST) ? '0 : slot_ff + 1'b1;
            end
            socf_pkg::ACT_OUT: begin
               if (go) begin
                  rsp_valid_ff <= 1'b1;
                  last_ff      <= q_res;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      case (uc.act)
         socf_pkg::ACT_LOAD: begin
            if (req_fire) begin
               acc_ff  <= req_tdata[15:0];
               gyro_ff <= req_tdata[31:16];
               us_ff   <= req_tdata[47:32];
            end
         end
         socf_pkg::ACT_ERR:    err_ff <= {acc_ff[15], acc_ff} - {last_ff[15], last_ff};
         socf_pkg::ACT_T_PROD: t_ff <= prod_ff[63:0];
         socf_pkg::ACT_DT: begin
            dt_ff <= t_ff[28:0]
                   + {12'd0, prod_ff[socf_pkg::DT_RECIP_SHIFT +: 17]};
         end
         socf_pkg::ACT_SUM_S:  s_ff <= s_calc;
         socf_pkg::ACT_T_ADD:  t_ff <= t_ff + {35'd0, prod_ff[44:16]};
         socf_pkg::ACT_EST:    est_ff <= est_sat;
         socf_pkg::ACT_DIFF:   t_ff <= diff;
         socf_pkg::ACT_ABS: begin
            neg_ff <= sum_ff[43];
            t_ff   <= {36'd0, sum_mag[43:16]};
         end
         socf_pkg::ACT_OUT: begin
            if (go) begin
               rsp_data_ff <= q_res;
            end
         end
         default: ;
      endcase
   end

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= socf_pkg::STEP_OUT)
      else $error("microcode step counter left the program");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (step_ff == socf_pkg::STEP_IDLE + 1'b1))
      else $error("accepted beat did not start the program");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> ($past(step_ff) == socf_pkg::STEP_OUT))
      else $error("result raised outside the output step");

   a_last_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (last_ff == rsp_data_ff))
      else $error("reference angle differs from pending result");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= SLOT_LAST)
      else $error("ring slot out of range");

endmodule

`default_nettype wire

>>> tb/filter_checker.sv
`timescale 1ns / 100ps

module filter_checker #(
   parameter int SMOOTH_LEN = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   // [15:0] acc_angle, [31:16] gyro_rate, [47:32] interval_us
   input  wire logic [47:0] req_tdata,

   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // [15:0] filtered_angle
   input  wire logic [15:0] rsp_tdata,

   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   input  wire logic        csr_pready,

   output int               mismatch_count = 0,
   output int               angles_owed = 0
);

   localparam logic [2:0] GAIN_ADDR = {socf_pkg::CSR_GAIN_IDX, 2'b00};
   localparam longint Q16_ONE = 65536;

   logic [7:0]         gain = socf_pkg::GAIN_RESET;
   longint             integ_q16 = 0;
   longint             history_q16 [SMOOTH_LEN];
   longint             history_sum_q16 = 0;
   int                 ring_slot = 0;
   logic signed [15:0] last_angle = '0;

   logic signed [15:0] expected_angles [$];
   logic signed [15:0] wanted_angle;
   int                 result_index = 0;

   function automatic longint clamp_signed(input longint v, input int bits);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
         return hi;
      end
      if (v < lo) begin
         return lo;
      end
      return v;
   endfunction

   // Advances the filter state by one reading and returns the smoothed angle.
   function automatic logic signed [15:0] next_filtered_angle(input logic [47:0] beat);
      longint          acc;
      longint          gyro;
      longint unsigned us;
      longint          k;
      longint          dt;
      longint          err;
      longint          s;
      longint          s_hi;
      longint          s_lo;
      longint          delta;
      longint          est;
      longint          q;
      acc = longint'($signed(beat[15:0]));
      gyro = longint'($signed(beat[31:16]));
      us = longint'(beat[47:32]);
      k = longint'(gain);
      dt = longint'((us << 32) / 64'd1000000);
      err = acc - longint'(last_angle);

      integ_q16 = clamp_signed(integ_q16 + ((k * k * err * dt) >>> 16), 48);

      s = integ_q16 + (2 * k * err + gyro) * Q16_ONE;
      s_hi = s >>> 16;
      s_lo = s - s_hi * Q16_ONE;
      delta = (dt * s_hi + ((dt * s_lo) >>> 16)) >>> 16;
      est = clamp_signed(longint'(last_angle) * Q16_ONE + delta, 40);

      history_sum_q16 = history_sum_q16 - history_q16[ring_slot] + est;
      history_q16[ring_slot] = est;
      ring_slot = (ring_slot + 1 >= SMOOTH_LEN) ? 0 : ring_slot + 1;

      q = clamp_signed(history_sum_q16 / (longint'(SMOOTH_LEN) * Q16_ONE), 16);
      last_angle = q[15:0];
      return q[15:0];
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t filter_checker: %s", $time, msg);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         gain = socf_pkg::GAIN_RESET;
         integ_q16 = 0;
         foreach (history_q16[i]) history_q16[i] = 0;
         history_sum_q16 = 0;
         ring_slot = 0;
         last_angle = '0;
         expected_angles.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
               && csr_paddr == GAIN_ADDR) begin
            gain = csr_pwdata[7:0];
         end
         if (req_tvalid && req_tready) begin
            expected_angles.push_back(next_filtered_angle(req_tdata));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_angles.size() == 0) begin
               report_mismatch($sformatf("unexpected result beat %0d, angle %0d",
                  result_index, $signed(rsp_tdata)));
            end else begin
               wanted_angle = expected_angles.pop_front();
               if (rsp_tdata !== wanted_angle) begin
                  report_mismatch($sformatf("result beat %0d: filtered_angle %0d, want %0d",
                     result_index, $signed(rsp_tdata), wanted_angle));
               end
            end
            result_index++;
         end
      end
      angles_owed = expected_angles.size();
   end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

   localparam int         SMOOTH_LEN   = 2;
   localparam int         LIMIT_CYCLES = 400000;
   localparam int         LONG_HOLD    = 300;
   localparam int         SETTLE       = 40;
   localparam logic [2:0] GAIN_ADDR    = {socf_pkg::CSR_GAIN_IDX, 2'b00};
   localparam logic [2:0] SPARE_ADDR   = {~socf_pkg::CSR_GAIN_IDX, 2'b00};

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_tvalid = 1'b0;
   wire  logic  req_tready;
   // [15:0] acc_angle, [31:16] gyro_rate, [47:32] interval_us
   logic [47:0] req_tdata = '0;

   wire  logic        rsp_tvalid;
   logic              rsp_tready = 1'b0;
   // [15:0] filtered_angle
   wire  logic [15:0] rsp_tdata;

   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   wire  logic [31:0] csr_prdata;
   wire  logic        csr_pready;

   int mismatch_count;
   int angles_owed;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_left = 0;
   logic hold_armed = 1'b0;
   logic hold_done = 1'b0;
   int trend_angle = 0;

   second_order_complementary_filter #(.SMOOTH_LEN(SMOOTH_LEN)) dut (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready
   );

   filter_checker #(.SMOOTH_LEN(SMOOTH_LEN)) scoreboard (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata, .csr_pready,
      .mismatch_count, .angles_owed
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("second_order_complementary_filter test failed");
         $finish;
      end
   end

   // The receiver stalls at random, and once holds off for a long stretch.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_armed && !hold_done) begin
         hold_left <= LONG_HOLD;
         hold_done <= 1'b1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic logic [47:0] pack_reading(input int acc, input int gyro, input int us);
      logic [15:0] a;
      logic [15:0] g;
      logic [15:0] u;
      a = acc[15:0];
      g = gyro[15:0];
      u = us[15:0];
      return {u, g, a};
   endfunction

   function automatic logic [47:0] random_reading();
      int acc;
      int gyro;
      int us;
      int pick;
      pick = $urandom_range(9);
      if (pick == 0) begin
         acc = 32767;
      end else if (pick == 1) begin
         acc = -32768;
      end else if (pick <= 5) begin
         trend_angle = trend_angle + int'($urandom_range(400)) - 200;
         if (trend_angle > 20000) trend_angle = 20000;
         if (trend_angle < -20000) trend_angle = -20000;
         acc = trend_angle;
      end else begin
         acc = int'($urandom());
      end
      pick = $urandom_range(9);
      if (pick == 0) begin
         gyro = 32767;
      end else if (pick == 1) begin
         gyro = -32768;
      end else if (pick <= 5) begin
         gyro = int'($urandom_range(2000)) - 1000;
      end else begin
         gyro = int'($urandom());
      end
      pick = $urandom_range(19);
      if (pick == 0) begin
         us = 0;
      end else if (pick == 1) begin
         us = 65535;
      end else if (pick <= 13) begin
         us = int'($urandom_range(5000, 100));
      end else begin
         us = int'($urandom());
      end
      return pack_reading(acc, gyro, us);
   endfunction

   task automatic push_sample(input logic [47:0] beat);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= beat;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (angles_owed != 0);
      @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_phase(input int gain, input int items, input int send_pct,
                               input int recv_pct);
      csr_write(GAIN_ADDR, 32'(gain));
      send_idle_pct = send_pct;
      recv_idle_pct <= recv_pct;
      repeat (items) push_sample(random_reading());
      drain();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 14;
      recv_idle_pct <= 81;
      csr_write(GAIN_ADDR, 32'(socf_pkg::GAIN_RESET));
      push_sample(pack_reading(0, 0, 0));
      push_sample(pack_reading(32767, 0, 0));
      push_sample(pack_reading(32767, 0, 1000));
      push_sample(pack_reading(32767, 32767, 65535));
      push_sample(pack_reading(32767, 32767, 65535));
      push_sample(pack_reading(-32768, -32768, 65535));
      push_sample(pack_reading(-32768, -32768, 65535));
      push_sample(pack_reading(0, 32767, 1));
      push_sample(pack_reading(0, -32768, 65535));
      push_sample(pack_reading(12345, -1000, 0));
      push_sample(pack_reading(-1, 1, 65535));
      push_sample(pack_reading(100, 0, 5000));
      drain();

      // The spare address must leave the gain untouched.
      csr_write(GAIN_ADDR, 32'd255);
      csr_write(SPARE_ADDR, 32'd0);
      repeat (3) push_sample(pack_reading(32767, 32767, 65535));
      repeat (3) push_sample(pack_reading(-32768, -32768, 65535));
      repeat (2) begin
         push_sample(pack_reading(32767, -32768, 65535));
         push_sample(pack_reading(-32768, 32767, 65535));
      end
      drain();

      random_phase(255, 150, 14, 81);
      random_phase(0, 120, 14, 81);
      random_phase(1, 150, 81, 14);
      random_phase(int'($urandom_range(254, 2)), 150, 81, 14);

      hold_armed <= 1'b1;
      random_phase(int'($urandom_range(254, 2)), 180, 0, 0);

      repeat (SETTLE) @(posedge clock);
      if (mismatch_count == 0 && angles_owed == 0) begin
         $display("second_order_complementary_filter test passed");
      end else begin
         $display("second_order_complementary_filter test failed");
      end
      $finish;
   end

endmodule

>>> second_order_complementary_filter.f
src/socf_pkg.sv
src/second_order_complementary_filter.sv
tb/filter_checker.sv
tb/tb_top.sv
